/* design/lwks_pkg.sv */
// Package: shared types, constants and the 4-bit S-box of the key schedule.
`timescale 1ns / 1ps
package lwks_pkg;

  localparam int HALF_W       = 40;  // width of each key half
  localparam int NIB_W        = 4;
  localparam int SUBKEY_W     = 16;
  localparam int RND_W        = 5;   // round index width
  localparam int NROUND_W     = 6;   // round count field width
  localparam int MAX_RESULTS  = 32;  // round keys one item can produce
  localparam int SLICE_ROUNDS = 5;   // leading keys taken straight from the master key

  typedef enum logic [0:0] {
    S_IDLE,
    S_WORK
  } lwks_state_t;

  // control from the sequencer to the nibble datapath
  typedef struct packed {
    logic load;  // take a new master key
    logic step;  // process one nibble
  } lwks_ctrl_t;

  function automatic logic [NIB_W-1:0] sbox4(input logic [NIB_W-1:0] v);
    logic [NIB_W-1:0] r;
    case (v)
      4'h0: r = 4'h0;
      4'h1: r = 4'h8;
      4'h2: r = 4'h6;
      4'h3: r = 4'hd;
      4'h4: r = 4'h5;
      4'h5: r = 4'hf;
      4'h6: r = 4'h7;
      4'h7: r = 4'hc;
      4'h8: r = 4'h4;
      4'h9: r = 4'he;
      4'ha: r = 4'h2;
      4'hb: r = 4'h3;
      4'hc: r = 4'h9;
      4'hd: r = 4'h1;
      4'he: r = 4'hb;
      4'hf: r = 4'ha;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

/* design/lwks_nibble_core.sv */
// Nibble-serial datapath: key half shift registers and round key collector.
`timescale 1ns / 1ps
module lwks_nibble_core import lwks_pkg::*; (
  input  logic                    clk,
  input  lwks_ctrl_t              ctrl,
  input  logic [SUBKEY_W-1:0]     key_upper,
  input  logic [63:0]             key_lower,
  output logic [2*HALF_W-1:0]     key_cat,
  output logic [SUBKEY_W-1:0]     sk_next
);

  logic [HALF_W-1:0]   hi;
  logic [HALF_W-1:0]   lo;
  logic [SUBKEY_W-1:0] sk;
  logic [NIB_W-1:0]    h;
  logic [NIB_W-1:0]    l;
  logic [NIB_W-1:0]    t;
  logic [NIB_W-1:0]    o;

  // lowest nibble is the one due next; results enter at the top, so after
  // ten steps the halves hold the updated key in place
  always_comb begin
    h       = hi[NIB_W-1:0];
    l       = lo[NIB_W-1:0];
    t       = sbox4({l[1:0], l[3:2]} ^ h);
    o       = {h[0], h[3:1]} ^ t;
    sk_next = {o, sk[SUBKEY_W-1:NIB_W]};
    key_cat = {hi, lo};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi <= {key_upper, key_lower[63:HALF_W]};
      lo <= key_lower[HALF_W-1:0];
    end else if (ctrl.step) begin
      hi <= {o, hi[HALF_W-1:NIB_W]};
      lo <= {t, lo[HALF_W-1:NIB_W]};
      sk <= sk_next;
    end
  end

endmodule

/* design/lightweight_cipher_key_schedule.sv */
// Top level: 80-bit-key schedule producing a stream of 16-bit round keys.
`timescale 1ns / 1ps
// One input item (80-bit key, round count) yields min(num_rounds, MAX_ROUNDS, 32)
// round keys on the subkey channel, indexed from zero, with is_last on the
// final one; a count of zero yields nothing. Keys 0..4 are the key's 16-bit
// slices, low to high. Later keys come from a nibble-serial update of the
// two 40-bit key halves, one nibble per cycle through a single S-box, except
// that the last nibble of a key waits while the output register is held; each
// key collects four nibbles. A finished key sits in the output register while
// the next one is computed; a new item is taken once the last key of the run
// has been loaded for output.
module lightweight_cipher_key_schedule import lwks_pkg::*; #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  output logic                key_ready,
  input  logic [15:0]         key_upper,
  input  logic [63:0]         key_lower,
  input  logic [5:0]          num_rounds,
  output logic                subkey_valid,
  input  logic                subkey_ready,
  output logic [15:0]         subkey,
  output logic [4:0]          subkey_index,
  output logic                is_last
);

  localparam int RND_CAP = (MAX_ROUNDS < MAX_RESULTS) ? MAX_ROUNDS : MAX_RESULTS;

  lwks_state_t          state;
  lwks_state_t          state_next;
  lwks_ctrl_t           ctrl;
  logic [RND_W-1:0]     rnd;
  logic [RND_W-1:0]     last_idx;
  logic [1:0]           dcnt;       // nibbles done in the current round key
  logic [NROUND_W-1:0]  n_eff;
  logic                 can_load;
  logic                 slice_phase;
  logic                 emit;
  logic [2*HALF_W-1:0]  key_cat;
  logic [SUBKEY_W-1:0]  sk_next;
  logic [SUBKEY_W-1:0]  slice;

  lwks_nibble_core u_core (
    .clk       (clk),
    .ctrl      (ctrl),
    .key_upper (key_upper),
    .key_lower (key_lower),
    .key_cat   (key_cat),
    .sk_next   (sk_next)
  );

  // round count clipped to what the block can produce
  assign n_eff = (num_rounds > NROUND_W'(RND_CAP)) ? NROUND_W'(RND_CAP) : num_rounds;

  always_comb begin
    case (rnd)
      5'd0:    slice = key_cat[15:0];
      5'd1:    slice = key_cat[31:16];
      5'd2:    slice = key_cat[47:32];
      5'd3:    slice = key_cat[63:48];
      default: slice = key_cat[79:64];
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (key_valid && n_eff != '0) state_next = S_WORK;
      end
      S_WORK: begin
        if (emit && rnd == last_idx) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    can_load    = !subkey_valid || subkey_ready;
    slice_phase = rnd < RND_W'(SLICE_ROUNDS);
    key_ready   = 1'b0;
    emit        = 1'b0;
    ctrl        = '0;
    case (state)
      S_IDLE: begin
        key_ready = 1'b1;
        ctrl.load = key_valid;
      end
      S_WORK: begin
        emit      = can_load && (slice_phase || dcnt == 2'd3);
        ctrl.step = !slice_phase && (dcnt != 2'd3 || can_load);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rnd          <= '0;
      dcnt         <= '0;
      subkey_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        rnd  <= '0;
        dcnt <= '0;
      end else begin
        if (emit) rnd <= rnd + 1'b1;
        if (ctrl.step) dcnt <= dcnt + 1'b1;
      end
      if (emit) begin
        subkey_valid <= 1'b1;
      end else if (subkey_ready) begin
        subkey_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.load) last_idx <= RND_W'(n_eff - 1'b1);
    if (emit) begin
      subkey       <= slice_phase ? slice : sk_next;
      subkey_index <= rnd;
      is_last      <= (rnd == last_idx);
    end
  end

`ifndef NO_ASSERTIONS
  // the nibble counter is back at zero whenever the block waits for a key
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> dcnt == 2'd0)
    else $error("nibble counter not cleared at end of run");

  // a pending key that is not the last means the run is still going
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    subkey_valid && !is_last |-> state == S_WORK)
    else $error("run ended before its last key");

  // a nonzero round count starts a run
  a_start: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready && num_rounds != 6'd0 |=> !key_ready)
    else $error("accepted item did not start a run");

  // slice keys never use the nibble unit
  a_slice_no_step: assert property (@(posedge clk) disable iff (rst)
    state == S_WORK && rnd < RND_W'(SLICE_ROUNDS) |-> !ctrl.step)
    else $error("nibble step during slice rounds");
`endif

endmodule

/* tb/tb_lightweight_cipher_key_schedule.sv */
// Testbench: self-checking stimulus and round-key prediction for the key schedule.
`timescale 1ns / 1ps
module tb_lightweight_cipher_key_schedule;
  import lwks_pkg::*;

  // DUT configuration; predictor saturates the round count the same way
  localparam int SCHED_MAX_ROUNDS = 32;
  localparam int RANDOM_ITEMS     = 185;  // random part, zero-round items not counted
  localparam int DRAIN_CYCLES     = 150;  // covers a full 32-key run after the last result

  // 4-bit substitution used by the nibble update
  localparam logic [NIB_W-1:0] SBOX [16] = '{
    4'h0, 4'h8, 4'h6, 4'hd, 4'h5, 4'hf, 4'h7, 4'hc,
    4'h4, 4'he, 4'h2, 4'h3, 4'h9, 4'h1, 4'hb, 4'ha
  };

  typedef struct packed {
    logic [SUBKEY_W-1:0] subkey;
    logic [RND_W-1:0]    idx;
    logic                is_last;
  } round_key_t;

  logic                clk;
  logic                rst;
  logic                key_valid;
  logic                key_ready;
  logic [15:0]         key_upper;
  logic [63:0]         key_lower;
  logic [NROUND_W-1:0] num_rounds;
  logic                subkey_valid;
  logic                subkey_ready;
  logic [15:0]         subkey;
  logic [4:0]          subkey_index;
  logic                is_last;

  round_key_t round_key_q[$];  // round keys still owed by the DUT, oldest first
  int         mismatch_cnt;
  bit         no_idle;         // when set, neither side inserts gaps

  lightweight_cipher_key_schedule #(
    .MAX_ROUNDS(SCHED_MAX_ROUNDS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_upper(key_upper),
    .key_lower(key_lower),
    .num_rounds(num_rounds),
    .subkey_valid(subkey_valid),
    .subkey_ready(subkey_ready),
    .subkey(subkey),
    .subkey_index(subkey_index),
    .is_last(is_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: expands one accepted item into its round keys.
  // Keys 0..3 are the 16-bit slices of key_lower, key 4 is key_upper.
  // From key 5 on, the two 40-bit halves are walked nibble by nibble from
  // index 9 (lsbs) down to 0 (msbs); each nibble yields
  //   t = S(rotl2(low) ^ high), out = rotl3(high) ^ t
  // with t and out becoming the next low/high nibbles. Once index 0 is done
  // the new halves take over and the walk wraps back to index 9, which can
  // happen in the middle of a round key.
  // ---------------------------------------------------------------------------
  function automatic void predict_round_keys(input logic [15:0] ku, input logic [63:0] kl,
                                             input logic [NROUND_W-1:0] nr);
    logic [HALF_W-1:0]   hi, lo, nhi, nlo;
    logic [NIB_W-1:0]    h, l, t, o;
    logic [SUBKEY_W-1:0] sk;
    round_key_t          rk;
    int                  n, pos, sh;
    hi  = {ku, kl[63:40]};
    lo  = kl[39:0];
    nhi = '0;
    nlo = '0;
    pos = 9;
    n   = nr;
    // round count saturates at the parameter and at the per-item capacity
    if (n > SCHED_MAX_ROUNDS) n = SCHED_MAX_ROUNDS;
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    for (int r = 0; r < n; r++) begin
      if (r < 4) begin
        sk = kl[16*r +: 16];
      end else if (r == 4) begin
        sk = ku;
      end else begin
        sk = '0;
        for (int y = 0; y < 4; y++) begin
          sh = 36 - 4 * pos;
          h  = hi[sh +: NIB_W];
          l  = lo[sh +: NIB_W];
          t  = SBOX[{l[1:0], l[3:2]} ^ h];
          o  = {h[0], h[3:1]} ^ t;
          nlo[sh +: NIB_W] = t;
          nhi[sh +: NIB_W] = o;
          sk[4*y +: NIB_W] = o;  // first processed nibble lands in bits 3..0
          if (pos == 0) begin
            hi  = nhi;
            lo  = nlo;
            nhi = '0;
            nlo = '0;
            pos = 9;
          end else begin
            pos--;
          end
        end
      end
      rk.subkey  = sk;
      rk.idx     = RND_W'(r);
      rk.is_last = (r + 1 == n);
      round_key_q.push_back(rk);
    end
  endfunction

  // Gap length: mostly none or short, now and then a long one.
  function automatic int rand_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted round key is compared with the oldest
  // prediction. Sampled at the rising edge, where the handshake completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    round_key_t exp_rk;
    if (!rst && subkey_valid && subkey_ready) begin
      if (round_key_q.size() == 0) begin
        $display("%0t: unexpected round key: got subkey %h index %0d last %0b",
                 $time, subkey, subkey_index, is_last);
        mismatch_cnt++;
      end else begin
        exp_rk = round_key_q.pop_front();
        if (subkey !== exp_rk.subkey) begin
          $display("%0t: subkey mismatch: expected %h, got %h", $time, exp_rk.subkey, subkey);
          mismatch_cnt++;
        end
        if (subkey_index !== exp_rk.idx) begin
          $display("%0t: subkey_index mismatch: expected %0d, got %0d",
                   $time, exp_rk.idx, subkey_index);
          mismatch_cnt++;
        end
        if (is_last !== exp_rk.is_last) begin
          $display("%0t: is_last mismatch: expected %0b, got %0b",
                   $time, exp_rk.is_last, is_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Output backpressure: bursts of ready broken by random stalls.
  initial begin
    int burst, gap;
    subkey_ready = 1'b0;
    @(negedge clk);
    forever begin
      burst = $urandom_range(1, 12);
      subkey_ready = 1'b1;
      repeat (burst) @(negedge clk);
      gap = rand_gap();
      if (gap > 0) begin
        subkey_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Send one item. Called and returning at a falling edge; valid stays high
  // on return so a following call can keep it up with no gap.
  // ---------------------------------------------------------------------------
  task automatic send_key(input logic [15:0] ku, input logic [63:0] kl,
                          input logic [NROUND_W-1:0] nr);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      key_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    key_valid  = 1'b1;
    key_upper  = ku;
    key_lower  = kl;
    num_rounds = nr;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    predict_round_keys(ku, kl, nr);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_lower();
    return {$urandom(), $urandom()};
  endfunction

  // Round counts weighted toward short and mid runs; a few full or over-range.
  function automatic logic [NROUND_W-1:0] rand_rounds();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 20) return NROUND_W'($urandom_range(1, SLICE_ROUNDS));
    if (sel < 80) return NROUND_W'($urandom_range(6, 20));
    if (sel < 93) return NROUND_W'($urandom_range(21, 32));
    return NROUND_W'($urandom_range(33, 63));
  endfunction

  // Slice-only runs: counts of five or fewer, zero rounds, field extremes.
  task automatic test_slice_rounds();
    send_key(16'h0000, 64'h0, 6'd1);
    send_key(16'hffff, 64'hffff_ffff_ffff_ffff, 6'd5);
    send_key(16'h1234, 64'h0123_4567_89ab_cdef, 6'd0);  // no round keys at all
    send_key(16'hbeef, 64'hdead_cafe_f00d_1234, 6'd3);
    send_key(16'h8001, 64'h8000_0000_0000_0001, 6'd4);
    send_key(16'h5a5a, 64'ha5a5_a5a5_a5a5_a5a5, 6'd2);
  endtask

  // Derived keys: first nibble-serial key, half-walk wrap inside a key,
  // full 32-key run and saturation of larger counts.
  task automatic test_round_limits();
    send_key(16'h0000, 64'h0, 6'd6);
    send_key(16'hffff, 64'hffff_ffff_ffff_ffff, 6'd8);  // key 7 straddles the wrap
    send_key(16'h0f0f, 64'h3c3c_c3c3_0ff0_f00f, 6'd15);
    send_key(16'h0000, 64'h0, 6'd32);
    send_key(16'hffff, 64'hffff_ffff_ffff_ffff, 6'd33);
    send_key(16'h7fff, 64'h7fff_ffff_0000_0000, 6'd63);  // all-ones count
    send_key(16'h0001, 64'h0000_0000_0000_0000, 6'd10);
    send_key(16'h0000, 64'h0000_0100_0000_0000, 6'd12);  // single bit at the half boundary
    send_key(16'h0000, 64'h0000_0080_0000_0000, 6'd12);
    send_key(16'h1357, 64'h2468_ace0_fdb9_7531, 6'd31);
  endtask

  // Random keys and counts with the usual idling on both sides.
  task automatic test_random_keys();
    int sent;
    logic [NROUND_W-1:0] nr;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      nr = rand_rounds();
      send_key(16'($urandom()), rand_lower(), nr);
      if (nr != 0) sent++;
    end
  endtask

  // Back-to-back items with no gaps on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) send_key(16'($urandom()), rand_lower(), rand_rounds());
    no_idle = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    key_valid    = 1'b0;
    key_upper    = '0;
    key_lower    = '0;
    num_rounds   = '0;
    mismatch_cnt = 0;
    no_idle      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_slice_rounds();
    test_round_limits();
    test_random_keys();
    test_back_to_back();
    key_valid = 1'b0;

    // let outstanding round keys drain, then allow for any trailing activity
    while (round_key_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && round_key_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every stall at its longest.
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* lightweight_cipher_key_schedule.f */
design/lwks_pkg.sv
design/lwks_nibble_core.sv
design/lightweight_cipher_key_schedule.sv
tb/tb_lightweight_cipher_key_schedule.sv
